@@ rtl/stcvm_pkg.sv @@
// shared types, constants and helpers for the symmetric tensor complex vector multiply unit
package stcvm_pkg;

	localparam int unsigned NUM_PROD  = 9;
	localparam int unsigned NUM_ROW   = 3;
	localparam int unsigned PART_W    = 16;
	localparam int unsigned CPLX_W    = 2 * PART_W;
	localparam int unsigned PROD_W    = 2 * PART_W;
	localparam int unsigned TERM_W    = PROD_W + 2;
	localparam int unsigned SUM_W     = 38;
	localparam int unsigned FRAC_BITS = 14;
	localparam int unsigned RES_PW    = 24;
	localparam int unsigned RES_W     = 2 * RES_PW;
	localparam int unsigned IN_DATA_W = 9 * CPLX_W;
	localparam int unsigned OUT_DATA_W = NUM_ROW * RES_W;
	localparam int unsigned IN_USER_W = 2;

	// tensor operand order in tdata: xx xy xz yy yz zz, then vector x y z
	localparam int unsigned VEC_BASE = 6;

	typedef enum logic [1:0] {
		SGN_POS,
		SGN_I,
		SGN_K,
		SGN_IK
	} sign_sel_t;

	typedef struct packed {
		logic signed [PART_W-1:0] re;
		logic signed [PART_W-1:0] im;
	} cplx16_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] ac;
		logic signed [PROD_W-1:0] bd;
		logic signed [PROD_W-1:0] ad;
		logic signed [PROD_W-1:0] bc;
	} prod_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] re;
		logic signed [TERM_W-1:0] im;
	} term_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] re;
		logic signed [SUM_W-1:0] im;
	} sum_t;

	typedef struct packed {
		logic rdy1;
		logic rdy2;
		logic rdy3;
	} pipe_ctl_t;

	// product n: tensor operand, vector operand, sign rule; rows are products 0-2, 3-5, 6-8
	localparam int unsigned MAT_IDX [NUM_PROD] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
	localparam int unsigned VEC_IDX [NUM_PROD] = '{0, 1, 2, 0, 1, 2, 0, 1, 2};
	localparam sign_sel_t   SGN_SEL [NUM_PROD] = '{SGN_POS, SGN_I, SGN_IK,
		SGN_I, SGN_POS, SGN_K, SGN_IK, SGN_K, SGN_POS};

	function automatic logic sign_neg(input sign_sel_t sel, input logic i_m, input logic k_m);
		logic neg;
		case (sel)
			SGN_POS: neg = 1'b0;
			SGN_I:   neg = i_m;
			SGN_K:   neg = k_m;
			SGN_IK:  neg = i_m ^ k_m;
			default: neg = 1'b0;
		endcase
		return neg;
	endfunction

	function automatic logic signed [TERM_W-1:0] sext_prod(input logic signed [PROD_W-1:0] p);
		return {{(TERM_W-PROD_W){p[PROD_W-1]}}, p};
	endfunction

	function automatic logic signed [SUM_W-1:0] sext_term(input logic signed [TERM_W-1:0] t);
		return {{(SUM_W-TERM_W){t[TERM_W-1]}}, t};
	endfunction

endpackage

@@ rtl/symmetric_tensor_complex_vector_multiply_unit.sv @@
// top level: pipelined symmetric 3x3 complex tensor times complex vector, one grid point per cycle
//
// usage
//   slave channel s_*: one grid point per transaction; s_tdata carries the six
//   tensor entries and three vector entries, 32 bits each (real 31:16, imag 15:0,
//   signed q2.14); s_tuser carries the two mirror flags
//   master channel m_*: one result per grid point, three 48-bit packed rows
//   (real 47:24, imag 23:0, signed q10.14)
//   pipeline: three register stages; m_tvalid is the valid bit of the last stage,
//   so the output transaction follows the input through all three registers
//   throughput: one transaction per cycle while m_tready is high, set by the three
//   register stages (multiply, complex combine with sign, row sum), each taking a
//   new point every cycle
//   reset: arst_n clears all stage valid bits; no results are pending afterwards
//   stall: when m_tready is low the last stage holds; earlier stages keep
//   filling empty slots, and s_tready falls only once all three stages hold data
//   results leave in the order the points came in
module symmetric_tensor_complex_vector_multiply_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz, vec_x, vec_y, vec_z
	input  logic [stcvm_pkg::IN_DATA_W-1:0]  s_tdata,
	// i_mirrored, k_mirrored
	input  logic [stcvm_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// res_x, res_y, res_z
	output logic [stcvm_pkg::OUT_DATA_W-1:0] m_tdata
);

	stcvm_pkg::pipe_ctl_t ctl;

	stcvm_pkg::cplx16_t op_in [9];

	stcvm_pkg::prod_t prod_s1 [stcvm_pkg::NUM_PROD];
	logic             i_s1;
	logic             k_s1;
	logic             v_s1;

	stcvm_pkg::term_t term_s2 [stcvm_pkg::NUM_PROD];
	logic             v_s2;

	stcvm_pkg::sum_t  sum_s3 [stcvm_pkg::NUM_ROW];
	logic             v_s3;

	always_comb begin
		ctl.rdy3 = !v_s3 || m_tready;
		ctl.rdy2 = !v_s2 || ctl.rdy3;
		ctl.rdy1 = !v_s1 || ctl.rdy2;
	end

	assign s_tready = ctl.rdy1;

	always_comb begin
		for (int n = 0; n < 9; n++) begin
			op_in[n] = s_tdata[n*stcvm_pkg::CPLX_W +: stcvm_pkg::CPLX_W];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ctl.rdy1) v_s1 <= s_tvalid;
			if (ctl.rdy2) v_s2 <= v_s1;
			if (ctl.rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1: real products
	always_ff @(posedge clk) begin
		if (ctl.rdy1 && s_tvalid) begin
			i_s1 <= s_tuser[0];
			k_s1 <= s_tuser[1];
			for (int n = 0; n < stcvm_pkg::NUM_PROD; n++) begin
				prod_s1[n].ac <= stcvm_pkg::PROD_W'(op_in[stcvm_pkg::MAT_IDX[n]].re
					* op_in[stcvm_pkg::VEC_BASE + stcvm_pkg::VEC_IDX[n]].re);
				prod_s1[n].bd <= stcvm_pkg::PROD_W'(op_in[stcvm_pkg::MAT_IDX[n]].im
					* op_in[stcvm_pkg::VEC_BASE + stcvm_pkg::VEC_IDX[n]].im);
				prod_s1[n].ad <= stcvm_pkg::PROD_W'(op_in[stcvm_pkg::MAT_IDX[n]].re
					* op_in[stcvm_pkg::VEC_BASE + stcvm_pkg::VEC_IDX[n]].im);
				prod_s1[n].bc <= stcvm_pkg::PROD_W'(op_in[stcvm_pkg::MAT_IDX[n]].im
					* op_in[stcvm_pkg::VEC_BASE + stcvm_pkg::VEC_IDX[n]].re);
			end
		end
	end

	// stage 2: complex combine and mirror sign
	always_ff @(posedge clk) begin
		if (ctl.rdy2 && v_s1) begin
			for (int n = 0; n < stcvm_pkg::NUM_PROD; n++) begin
				if (stcvm_pkg::sign_neg(stcvm_pkg::SGN_SEL[n], i_s1, k_s1)) begin
					term_s2[n].re <= stcvm_pkg::sext_prod(prod_s1[n].bd)
						- stcvm_pkg::sext_prod(prod_s1[n].ac);
					term_s2[n].im <= -stcvm_pkg::sext_prod(prod_s1[n].ad)
						- stcvm_pkg::sext_prod(prod_s1[n].bc);
				end else begin
					term_s2[n].re <= stcvm_pkg::sext_prod(prod_s1[n].ac)
						- stcvm_pkg::sext_prod(prod_s1[n].bd);
					term_s2[n].im <= stcvm_pkg::sext_prod(prod_s1[n].ad)
						+ stcvm_pkg::sext_prod(prod_s1[n].bc);
				end
			end
		end
	end

	// stage 3: row sums
	always_ff @(posedge clk) begin
		if (ctl.rdy3 && v_s2) begin
			for (int r = 0; r < stcvm_pkg::NUM_ROW; r++) begin
				sum_s3[r].re <= stcvm_pkg::sext_term(term_s2[3*r].re)
					+ stcvm_pkg::sext_term(term_s2[3*r+1].re)
					+ stcvm_pkg::sext_term(term_s2[3*r+2].re);
				sum_s3[r].im <= stcvm_pkg::sext_term(term_s2[3*r].im)
					+ stcvm_pkg::sext_term(term_s2[3*r+1].im)
					+ stcvm_pkg::sext_term(term_s2[3*r+2].im);
			end
		end
	end

	// floor shift is a plain bit select of the sign-extended sum
	always_comb begin
		for (int r = 0; r < stcvm_pkg::NUM_ROW; r++) begin
			m_tdata[r*stcvm_pkg::RES_W +: stcvm_pkg::RES_W] = {
				sum_s3[r].re[stcvm_pkg::FRAC_BITS +: stcvm_pkg::RES_PW],
				sum_s3[r].im[stcvm_pkg::FRAC_BITS +: stcvm_pkg::RES_PW]};
		end
	end

	assign m_tvalid = v_s3;

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3))
		else $error("s_tready low with an empty stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted transaction did not reach stage 1");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ctl.rdy3) |=> (v_s2 && $stable(term_s2[0]) && $stable(term_s2[8])))
		else $error("stage 2 changed while blocked");

	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ctl.rdy2) |=> v_s2)
		else $error("stage 1 data lost on advance");

endmodule

@@ bench/tb.sv @@
// testbench for the tensor vector multiply unit: directed and random grid points checked against a local predictor
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned XX = 0;
	localparam int unsigned XY = 1;
	localparam int unsigned XZ = 2;
	localparam int unsigned YY = 3;
	localparam int unsigned YZ = 4;
	localparam int unsigned ZZ = 5;
	localparam int unsigned RANDOM_POINTS = 600;
	localparam int unsigned PRESSURE_POINTS = 40;
	localparam int unsigned LONG_HOLD = 300;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam logic [15:0] PART_MAX = 16'h7fff;
	localparam logic [15:0] PART_MIN = 16'h8000;
	localparam logic [15:0] PART_ONE = 16'h4000;
	localparam logic [15:0] PART_LSB_NEG = 16'hffff;

	typedef struct packed {
		logic                 k_mirrored;
		logic                 i_mirrored;
		logic [8:0][stcvm_pkg::CPLX_W-1:0] operand;
	} grid_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// tensor_xx, tensor_xy, tensor_xz, tensor_yy, tensor_yz, tensor_zz, vec_x, vec_y, vec_z
	logic [stcvm_pkg::IN_DATA_W-1:0] s_tdata = '0;
	// i_mirrored, k_mirrored
	logic [stcvm_pkg::IN_USER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// res_x, res_y, res_z
	logic [stcvm_pkg::OUT_DATA_W-1:0] m_tdata;

	logic [stcvm_pkg::OUT_DATA_W-1:0] pending_fields [$];
	logic [stcvm_pkg::OUT_DATA_W-1:0] oldest_field;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit src_idle_on = 1'b0;
	bit sink_idle_on = 1'b0;
	bit long_hold_req = 1'b0;
	int unsigned sink_hold = 0;

	symmetric_tensor_complex_vector_multiply_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// tensor row times vector for each of the three rows, floor-scaled back to q10.14
	function automatic logic [stcvm_pkg::OUT_DATA_W-1:0] dipole_field(
			input logic [stcvm_pkg::IN_DATA_W-1:0] ops, input logic i_m, input logic k_m);
		logic [stcvm_pkg::OUT_DATA_W-1:0] field;
		logic [stcvm_pkg::CPLX_W-1:0] m;
		logic [stcvm_pkg::CPLX_W-1:0] v;
		int unsigned t_idx;
		longint a, b, c, d, pr, pi, sr, si;
		bit neg;
		field = '0;
		for (int r = 0; r < stcvm_pkg::NUM_ROW; r++) begin
			sr = 0;
			si = 0;
			for (int col = 0; col < stcvm_pkg::NUM_ROW; col++) begin
				case (r * stcvm_pkg::NUM_ROW + col)
					0: t_idx = XX;
					1, 3: t_idx = XY;
					2, 6: t_idx = XZ;
					4: t_idx = YY;
					5, 7: t_idx = YZ;
					default: t_idx = ZZ;
				endcase
				case (t_idx)
					XY: neg = i_m;
					XZ: neg = i_m ^ k_m;
					YZ: neg = k_m;
					default: neg = 1'b0;
				endcase
				m = ops[t_idx*stcvm_pkg::CPLX_W +: stcvm_pkg::CPLX_W];
				v = ops[(stcvm_pkg::VEC_BASE+col)*stcvm_pkg::CPLX_W +: stcvm_pkg::CPLX_W];
				a = longint'($signed(m[31:16]));
				b = longint'($signed(m[15:0]));
				c = longint'($signed(v[31:16]));
				d = longint'($signed(v[15:0]));
				pr = a * c - b * d;
				pi = a * d + b * c;
				if (neg) begin
					sr = sr - pr;
					si = si - pi;
				end else begin
					sr = sr + pr;
					si = si + pi;
				end
			end
			sr = sr >>> stcvm_pkg::FRAC_BITS;
			si = si >>> stcvm_pkg::FRAC_BITS;
			field[r*stcvm_pkg::RES_W +: stcvm_pkg::RES_W] =
				{sr[stcvm_pkg::RES_PW-1:0], si[stcvm_pkg::RES_PW-1:0]};
		end
		return field;
	endfunction

	function automatic logic [15:0] random_part();
		case ($urandom_range(0, 9))
			0: return PART_MAX;
			1: return PART_MIN;
			2: return 16'h0000;
			3: return PART_LSB_NEG;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic grid_point_t random_point();
		grid_point_t p;
		for (int n = 0; n < 9; n++)
			p.operand[n] = {random_part(), random_part()};
		p.i_mirrored = 1'($urandom_range(0, 1));
		p.k_mirrored = 1'($urandom_range(0, 1));
		return p;
	endfunction

	function automatic grid_point_t uniform_point(input logic [stcvm_pkg::CPLX_W-1:0] t,
			input logic [stcvm_pkg::CPLX_W-1:0] v, input logic i_m, input logic k_m);
		grid_point_t p;
		for (int n = 0; n < stcvm_pkg::VEC_BASE; n++)
			p.operand[n] = t;
		for (int n = stcvm_pkg::VEC_BASE; n < 9; n++)
			p.operand[n] = v;
		p.i_mirrored = i_m;
		p.k_mirrored = k_m;
		return p;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned gap_length();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [stcvm_pkg::RES_W-1:0] got,
			input logic [stcvm_pkg::RES_W-1:0] want);
		$display("mismatch %s: got %h expected %h", what, got, want);
		error_count++;
	endtask

	task automatic send_point(input grid_point_t p);
		int unsigned gap;
		gap = 0;
		s_tvalid <= 1'b1;
		s_tdata <= p.operand;
		s_tuser <= {p.k_mirrored, p.i_mirrored};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (src_idle_on && $urandom_range(0, 99) < 40)
			gap = gap_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		grid_point_t p;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		send_point(uniform_point('0, '0, 1'b0, 1'b0));
		for (int f = 0; f < 4; f++) begin
			send_point(uniform_point({PART_MAX, PART_MAX}, {PART_MAX, PART_MAX}, f[0], f[1]));
			send_point(uniform_point({PART_MIN, PART_MIN}, {PART_MIN, PART_MIN}, f[0], f[1]));
		end
		send_point(uniform_point({PART_MIN, PART_MIN}, {PART_MAX, PART_MAX}, 1'b0, 1'b0));
		send_point(uniform_point({PART_MAX, PART_MIN}, {PART_MIN, PART_MAX}, 1'b1, 1'b1));
		// one lsb products: floor must round toward minus infinity
		send_point(uniform_point({PART_LSB_NEG, 16'h0000}, {16'h0001, 16'h0000}, 1'b0, 1'b0));
		send_point(uniform_point({PART_LSB_NEG, PART_LSB_NEG}, {PART_LSB_NEG, PART_LSB_NEG},
			1'b0, 1'b1));
		// identity tensor passes the vector through
		p = uniform_point('0, '0, 1'b1, 1'b0);
		p.operand[XX] = {PART_ONE, 16'h0000};
		p.operand[YY] = {PART_ONE, 16'h0000};
		p.operand[ZZ] = {PART_ONE, 16'h0000};
		for (int n = stcvm_pkg::VEC_BASE; n < 9; n++)
			p.operand[n] = $urandom;
		send_point(p);
		wait_idle();
	endtask

	task automatic test_mirror_flags();
		grid_point_t p;
		// off-diagonal only, every flag combination, both signs
		for (int f = 0; f < 8; f++) begin
			p = random_point();
			p.operand[XX] = '0;
			p.operand[YY] = '0;
			p.operand[ZZ] = '0;
			if (f >= 4) begin
				p.operand[XY] = {PART_MIN, PART_MAX};
				p.operand[XZ] = {PART_MAX, PART_MIN};
				p.operand[YZ] = {PART_MIN, PART_MIN};
			end
			p.i_mirrored = f[0];
			p.k_mirrored = f[1];
			send_point(p);
		end
		wait_idle();
	endtask

	task automatic test_random_stream();
		logic [1:0] mode;
		mode = '0;
		for (int n = 0; n < RANDOM_POINTS; n++) begin
			if (n % 50 == 0) begin
				mode = 2'($urandom_range(0, 3));
				src_idle_on = mode[0];
				sink_idle_on = mode[1];
			end
			send_point(random_point());
		end
		wait_idle();
	endtask

	task automatic test_back_pressure();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		long_hold_req = 1'b1;
		for (int n = 0; n < PRESSURE_POINTS; n++)
			send_point(random_point());
		wait_idle();
	endtask

	// receiver: random stalls plus one long hold on request
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			sink_hold = LONG_HOLD;
		end
		if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			sink_hold = gap_length() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// predict on each accepted input transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			pending_fields.push_back(dipole_field(s_tdata, s_tuser[0], s_tuser[1]));
	end

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_fields.size() == 0) begin
				report_mismatch("unexpected result", m_tdata[stcvm_pkg::RES_W-1:0], '0);
			end else begin
				oldest_field = pending_fields.pop_front();
				if (m_tdata[0 +: stcvm_pkg::RES_W] !== oldest_field[0 +: stcvm_pkg::RES_W])
					report_mismatch("res_x", m_tdata[0 +: stcvm_pkg::RES_W],
						oldest_field[0 +: stcvm_pkg::RES_W]);
				if (m_tdata[stcvm_pkg::RES_W +: stcvm_pkg::RES_W]
						!== oldest_field[stcvm_pkg::RES_W +: stcvm_pkg::RES_W])
					report_mismatch("res_y", m_tdata[stcvm_pkg::RES_W +: stcvm_pkg::RES_W],
						oldest_field[stcvm_pkg::RES_W +: stcvm_pkg::RES_W]);
				if (m_tdata[2*stcvm_pkg::RES_W +: stcvm_pkg::RES_W]
						!== oldest_field[2*stcvm_pkg::RES_W +: stcvm_pkg::RES_W])
					report_mismatch("res_z", m_tdata[2*stcvm_pkg::RES_W +: stcvm_pkg::RES_W],
						oldest_field[2*stcvm_pkg::RES_W +: stcvm_pkg::RES_W]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_mirror_flags();
		test_back_pressure();
		test_random_stream();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_fields.size() != 0)
			report_mismatch("result missing", '0, '0);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
